@@ src/sepd_pkg.sv @@
// types, constants and helpers shared by the sensor energy peak detector
`timescale 1ns / 1ps

package sepd_pkg;

	localparam int VAL_W = 40;
	localparam int LIM_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int MODE_COUNT = 5;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 28;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	// floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for x below 2^30
	localparam logic [MUL_B_W-1:0] DIV10_RECIP = 28'd214748365;
	localparam int DIV10_SHIFT = 31;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_LIMIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 8'd3;

	localparam logic [15:0] ALPHA_RESET = 16'd10923;
	localparam logic [LIM_W-1:0] RISE_RESET = 16'd4;
	localparam logic [LIM_W-1:0] FALL_RESET = 16'd4;
	localparam logic [VAL_W-1:0] DEADBAND_RESET = 40'd0;

	typedef enum logic [2:0] {
		MODE_FLAT      = 3'd0,
		MODE_FLAT_UP   = 3'd1,
		MODE_FLAT_DOWN = 3'd2,
		MODE_HILL_UP   = 3'd3,
		MODE_HILL_DOWN = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_SQ,
		ST_ERG,
		ST_MLO,
		ST_MHI,
		ST_FILT,
		ST_DET,
		ST_MEAN,
		ST_OUT
	} state_t;

	// increment that sticks at all ones
	function automatic logic [LIM_W-1:0] sat_inc(input logic [LIM_W-1:0] v);
		return (v == {LIM_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

@@ src/sensor_energy_peak_detector.sv @@
// top level of the sensor energy peak detector
`timescale 1ns / 1ps

// sensor energy peak detector
//
// input channel: in_valid / in_ready with a signed 16 bit sample. in_ready is
// high only while the sequencer is idle; one transaction starts one item.
// output channel: out_valid / out_ready with filtered_value, window_mean,
// detector_mode and slope_up, held in an output register until taken.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// lpf_alpha, rise_count_limit, fall_count_limit or slope_deadband; other
// indexes are dropped. write only while no item is in flight.
// one shared multiplier does the divide by ten of the running
// average, the square, both halves of the filter product and, when WINDOW
// is not a power of two, four partial products of a reciprocal multiply for
// the window mean. an item steps through div, avg, sq, erg, mlo, mhi, filt,
// det, then mean if WINDOW is not a power of two, and out; one at a time.
// the next sample is accepted while a result waits in the output register;
// a stalled receiver holds the sequencer at its last step once a second
// result is ready.
// reset: sequencer, config, average, window, sum, detector and out_valid are reset; datapath and output data are not.
module sensor_energy_peak_detector #(
	parameter int WINDOW = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [15:0]                     sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [sepd_pkg::VAL_W-1:0]             filtered_value,
	output logic [sepd_pkg::VAL_W-1:0]             window_mean,
	output logic [2:0]                             detector_mode,
	output logic                                   slope_up,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sepd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sepd_pkg::VAL_W-1:0]             cfg_data
);
	import sepd_pkg::*;

	// window sum widths
	localparam int LOG_W = $clog2(WINDOW);
	localparam int TOTAL_W = VAL_W + LOG_W;
	localparam bit POW2 = ((WINDOW & (WINDOW - 1)) == 0);

	// floor(total / WINDOW) == (total * MEAN_RECIP) >> MEAN_SHIFT,
	// total split in two 24 bit halves, reciprocal in two 25 bit halves
	localparam int MEAN_SHIFT = VAL_W + 2 * LOG_W;
	localparam int MX_W = 48;
	localparam int MX_H = 24;
	localparam int MR_W = 50;
	localparam int MR_H = 25;
	localparam int MACC_W = MX_W + MR_W;
	localparam longint unsigned MEAN_ONE = 64'd1 << MEAN_SHIFT;
	localparam logic [MR_W-1:0] MEAN_RECIP =
		MR_W'((MEAN_ONE + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [2:0] MSTEP_LAST = 3'd4;

	// configuration registers
	logic [15:0]      alpha_q;
	logic [LIM_W-1:0] rise_lim_q;
	logic [LIM_W-1:0] fall_lim_q;
	logic [VAL_W-1:0] deadband_q;

	// sequencer
	state_t state_q, state_d;

	// per item datapath
	logic signed [15:0] sample_q;
	logic [MUL_A_W-1:0] div_op_q;
	logic               div_neg_q;
	logic signed [24:0] avg_q;
	logic [24:0]        mag_q;
	logic [VAL_W-1:0]   dmag_q;
	logic               dneg_q;
	logic [35:0]        acc_lo_q;
	logic [VAL_W-1:0]   filt_q;
	logic               up_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_q;

	// window shift line and running sum
	logic [VAL_W-1:0]   win_q [WINDOW];
	logic [TOTAL_W-1:0] total_q;

	// reciprocal multiply for the mean
	logic [2:0]         mstep_q;
	logic [MACC_W-1:0]  macc_q;
	logic [MX_W-1:0]    mean_x;
	logic [5:0]         mean_sh;

	// hill detector
	mode_t            mode_q;
	logic [LIM_W-1:0] cnt_q [MODE_COUNT];
	mode_t            mode_d;
	logic [LIM_W-1:0] cnt_d [MODE_COUNT];

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] out_filt_q;
	logic [VAL_W-1:0] out_mean_q;
	mode_t            out_mode_q;
	logic             out_up_q;

	logic in_fire;
	logic out_free;

	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------
	// combinational datapath
	// ---------------------------------------------------------------

	// n = 9 * avg + 256 * sample + 5, operand for the floor divide by ten
	logic signed [29:0] avg_n;
	logic [MUL_A_W-1:0] div_op_d;
	assign avg_n = (30'(avg_q) <<< 3) + 30'(avg_q) + (30'(sample) <<< 8) + 30'sd5;
	assign div_op_d = avg_n[29] ? MUL_A_W'(30'sd9 - avg_n) : MUL_A_W'(avg_n);

	// new average and deviation magnitude
	logic [25:0]        quo10;
	logic signed [25:0] avg_new;
	logic signed [25:0] dev;
	assign quo10 = prod_q[PROD_W-1:DIV10_SHIFT];
	assign avg_new = div_neg_q ? -$signed({1'b0, quo10[24:0]}) : $signed({1'b0, quo10[24:0]});
	assign dev = (26'(sample_q) <<< 8) - avg_new;

	// energy = (dev^2 + 128) >> 8, then its signed distance from the previous value
	logic [PROD_W:0]  e_sum;
	logic [VAL_W-1:0] energy;
	logic [VAL_W:0]   ediff;
	assign e_sum = {1'b0, prod_q} + (PROD_W + 1)'(128);
	assign energy = (|e_sum[PROD_W:VAL_W+8]) ? VAL_MAX : e_sum[VAL_W+7:8];
	assign ediff = {1'b0, energy} - {1'b0, win_q[WINDOW-1]};

	// filter: 65536 * prev + alpha * (energy - prev) + 32768, then >> 16
	logic [56:0]    f_scaled;
	logic [56:0]    f_base;
	logic [57:0]    f_sum;
	logic [VAL_W-1:0] filt_d;
	assign f_scaled = 57'({prod_q[35:0], 20'd0}) + 57'(acc_lo_q);
	assign f_base = {1'b0, win_q[WINDOW-1], 16'd0} + 57'd32768;
	assign f_sum = dneg_q ? ({1'b0, f_base} - {1'b0, f_scaled})
		: ({1'b0, f_base} + {1'b0, f_scaled});
	assign filt_d = (|f_sum[57:56]) ? VAL_MAX : f_sum[55:16];

	// slope from the newest value against the one before it
	logic [VAL_W-1:0] slope_diff;
	logic             up_d;
	assign slope_diff = (filt_q >= win_q[WINDOW-1]) ? filt_q - win_q[WINDOW-1]
		: win_q[WINDOW-1] - filt_q;
	assign up_d = !((slope_diff > deadband_q) && (filt_q < win_q[WINDOW-1]));

	// window sum after the shift
	logic [TOTAL_W-1:0] total_d;
	assign total_d = total_q - TOTAL_W'(win_q[0]) + TOTAL_W'(filt_q);

	// mean operand and the weight of the partial product that lands this cycle
	assign mean_x = MX_W'(total_q);

	always_comb begin
		case (mstep_q)
			3'd2: mean_sh = 6'(MR_H);
			3'd3: mean_sh = 6'(MX_H);
			3'd4: mean_sh = 6'(MX_H + MR_H);
			default: mean_sh = '0;
		endcase
	end

	logic [VAL_W-1:0] mean_d;
	assign mean_d = POW2 ? total_q[TOTAL_W-1:LOG_W] : macc_q[MEAN_SHIFT +: VAL_W];

	// hill detector rules, applied in order, each seeing the last one's result
	always_comb begin
		mode_d = mode_q;
		for (int i = 0; i < MODE_COUNT; i++) cnt_d[i] = cnt_q[i];

		if (mode_d == MODE_FLAT && up_q) begin
			mode_d = MODE_FLAT_UP;
			cnt_d[MODE_FLAT_UP] = '0;
		end

		if (mode_d == MODE_FLAT_UP && up_q && cnt_d[MODE_FLAT_UP] < rise_lim_q)
			cnt_d[MODE_FLAT_UP] = sat_inc(cnt_d[MODE_FLAT_UP]);
		if (mode_d == MODE_FLAT_UP && !up_q) begin
			mode_d = MODE_FLAT_DOWN;
			cnt_d[MODE_FLAT_DOWN] = '0;
		end
		if (mode_d == MODE_FLAT_UP && up_q && cnt_d[MODE_FLAT_UP] >= rise_lim_q) begin
			mode_d = MODE_HILL_UP;
			cnt_d[MODE_HILL_UP] = '0;
		end

		if (mode_d == MODE_FLAT_DOWN && !up_q && cnt_d[MODE_FLAT_DOWN] < fall_lim_q)
			cnt_d[MODE_FLAT_DOWN] = sat_inc(cnt_d[MODE_FLAT_DOWN]);
		if (mode_d == MODE_FLAT_DOWN && !up_q && cnt_d[MODE_FLAT_DOWN] >= fall_lim_q) begin
			mode_d = MODE_FLAT;
			cnt_d[MODE_FLAT] = '0;
		end
		if (mode_d == MODE_FLAT_DOWN && up_q) begin
			mode_d = MODE_FLAT_UP;
			cnt_d[MODE_FLAT_UP] = '0;
		end

		if (mode_d == MODE_HILL_UP && up_q)
			cnt_d[MODE_HILL_UP] = sat_inc(cnt_d[MODE_HILL_UP]);
		if (mode_d == MODE_HILL_UP && !up_q) begin
			mode_d = MODE_HILL_DOWN;
			cnt_d[MODE_HILL_DOWN] = '0;
		end

		if (mode_d == MODE_HILL_DOWN && !up_q && cnt_d[MODE_HILL_DOWN] < fall_lim_q)
			cnt_d[MODE_HILL_DOWN] = sat_inc(cnt_d[MODE_HILL_DOWN]);
		if (mode_d == MODE_HILL_DOWN && up_q) begin
			mode_d = MODE_HILL_UP;
			cnt_d[MODE_HILL_UP] = '0;
		end
		if (mode_d == MODE_HILL_DOWN && !up_q && cnt_d[MODE_HILL_DOWN] >= fall_lim_q) begin
			mode_d = MODE_FLAT;
			cnt_d[MODE_FLAT] = '0;
		end
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV:  state_d = ST_AVG;
			ST_AVG:  state_d = ST_SQ;
			ST_SQ:   state_d = ST_ERG;
			ST_ERG:  state_d = ST_MLO;
			ST_MLO:  state_d = ST_MHI;
			ST_MHI:  state_d = ST_FILT;
			ST_FILT: state_d = ST_DET;
			ST_DET:  state_d = POW2 ? ST_OUT : ST_MEAN;
			ST_MEAN: if (mstep_q == MSTEP_LAST) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and multiplier operand select
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DIV: begin
				mul_a = div_op_q;
				mul_b = DIV10_RECIP;
			end
			ST_SQ: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(mag_q);
			end
			ST_MLO: begin
				mul_a = MUL_A_W'(dmag_q[19:0]);
				mul_b = MUL_B_W'(alpha_q);
			end
			ST_MHI: begin
				mul_a = MUL_A_W'(dmag_q[39:20]);
				mul_b = MUL_B_W'(alpha_q);
			end
			// one partial product of total * reciprocal per step
			ST_MEAN: begin
				case (mstep_q)
					3'd0: begin
						mul_a = MUL_A_W'(mean_x[MX_H-1:0]);
						mul_b = MUL_B_W'(MEAN_RECIP[MR_H-1:0]);
					end
					3'd1: begin
						mul_a = MUL_A_W'(mean_x[MX_H-1:0]);
						mul_b = MUL_B_W'(MEAN_RECIP[MR_W-1:MR_H]);
					end
					3'd2: begin
						mul_a = MUL_A_W'(mean_x[MX_W-1:MX_H]);
						mul_b = MUL_B_W'(MEAN_RECIP[MR_H-1:0]);
					end
					3'd3: begin
						mul_a = MUL_A_W'(mean_x[MX_W-1:MX_H]);
						mul_b = MUL_B_W'(MEAN_RECIP[MR_W-1:MR_H]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// the one multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			rise_lim_q <= RISE_RESET;
			fall_lim_q <= FALL_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LPF_ALPHA:  alpha_q <= cfg_data[15:0];
				REG_RISE_LIMIT: rise_lim_q <= cfg_data[LIM_W-1:0];
				REG_FALL_LIMIT: fall_lim_q <= cfg_data[LIM_W-1:0];
				REG_DEADBAND:   deadband_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				sample_q <= sample;
				div_op_q <= div_op_d;
				div_neg_q <= avg_n[29];
			end
			ST_AVG: mag_q <= dev[25] ? 25'(-dev) : 25'(dev);
			ST_ERG: begin
				dneg_q <= ediff[VAL_W];
				dmag_q <= ediff[VAL_W] ? VAL_W'(-ediff) : ediff[VAL_W-1:0];
			end
			ST_MHI: acc_lo_q <= prod_q[35:0];
			ST_FILT: filt_q <= filt_d;
			ST_DET: begin
				up_q <= up_d;
				macc_q <= '0;
				mstep_q <= '0;
			end
			// the product issued on the step before lands here
			ST_MEAN: begin
				if (mstep_q != 3'd0)
					macc_q <= macc_q + (MACC_W'(prod_q) << mean_sh);
				mstep_q <= mstep_q + 3'd1;
			end
			default: ;
		endcase
	end

	// block state: average, window, sum, detector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			total_q <= '0;
			mode_q <= MODE_FLAT;
			for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
			for (int i = 0; i < MODE_COUNT; i++) cnt_q[i] <= '0;
		end else begin
			if (state_q == ST_AVG) avg_q <= avg_new[24:0];
			if (state_q == ST_DET) begin
				for (int i = 0; i < WINDOW - 1; i++) win_q[i] <= win_q[i+1];
				win_q[WINDOW-1] <= filt_q;
				total_q <= total_d;
			end
			// the detector takes the slope after it is judged: at the last mean step, else in out
			if (state_q == ST_DET && POW2) begin
				mode_q <= mode_q;
			end
			if ((state_q == ST_MEAN && mstep_q == MSTEP_LAST) || (state_q == ST_OUT
				&& POW2 && out_free)) begin
				mode_q <= mode_d;
				for (int i = 0; i < MODE_COUNT; i++) cnt_q[i] <= cnt_d[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_filt_q <= win_q[WINDOW-1];
			out_mean_q <= mean_d;
			out_mode_q <= POW2 ? mode_d : mode_q;
			out_up_q <= up_q;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_value = out_filt_q;
	assign window_mean = out_mean_q;
	assign detector_mode = out_mode_q;
	assign slope_up = out_up_q;

`ifndef NO_ASSERTIONS
	// an accepted sample keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// the filter sum never goes below zero
	a_filter_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILT && dneg_q) |-> (f_base >= f_scaled))
		else $error("filter accumulator underflow");

	// a saturated hill-up counter either stays or is cleared
	a_counter_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[MODE_HILL_UP] == {LIM_W{1'b1}}) |=>
		(cnt_q[MODE_HILL_UP] == {LIM_W{1'b1}} || cnt_q[MODE_HILL_UP] == '0))
		else $error("hill-up counter wrapped");
`endif

endmodule
